### hw/rtl/suks_pkg.sv
// suks_pkg: shared types and constants for the sorted unique key set
// no dependencies
package suks_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam int KEY_BITS_DEF = 32;

    localparam int OP_W     = 2;
    localparam int MASK_W   = 6;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 11;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_HIT       = 3'd4;
    localparam logic [STATUS_W-1:0] ST_MISS      = 3'd5;
    localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd6;

    localparam logic [MASK_W-1:0] PFX_8  = 6'd8;
    localparam logic [MASK_W-1:0] PFX_16 = 6'd16;
    localparam logic [MASK_W-1:0] PFX_24 = 6'd24;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture the item
        logic srch_init;  // reset search bounds
        logic srch_step;  // one binary search step (issues read)
        logic rd_pos;     // read entry at lo
        logic chk;        // compare read data at lo
        logic shift_init; // set shift pointer to count
        logic shift_rd;   // read entry at ptr-1
        logic shift_wr;   // write read data to ptr, decrement
        logic put;        // write key at pos, bump count
        logic clr;        // empty the set
        logic done;       // present result
    } suks_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_insert;
        logic is_lookup;
        logic is_clear;
        logic key_zero;
        logic srch_done;
        logic found;
        logic full;
        logic shift_done;
    } suks_stat_t;

endpackage

### hw/rtl/suks_ctrl.sv
// suks_ctrl: sequencer for search, shift and insert
// depends on suks_pkg
module suks_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    output suks_pkg::suks_cmd_t  cmd,
    input  suks_pkg::suks_stat_t stat
);

    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_SRCH, S_SWAIT, S_RDPOS, S_CHK, S_SHRD, S_SHWR, S_PUT, S_DONE
    } state_t;

    state_t state_reg;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        cmd = '0;
        cmd.load = (state_reg == S_IDLE) && start;
        unique case (state_reg)
            S_IDLE: ;
            S_DEC:
            begin
                if (stat.is_clear)
                    cmd.clr = 1'b1;
                else
                    cmd.srch_init = 1'b1;
            end
            S_SRCH:  cmd.srch_step = !stat.srch_done;
            S_SWAIT: ;
            S_RDPOS: cmd.rd_pos = 1'b1;
            S_CHK:
            begin
                cmd.chk = 1'b1;
                cmd.shift_init = 1'b1;
            end
            S_SHRD:  cmd.shift_rd = !stat.shift_done;
            S_SHWR:  cmd.shift_wr = 1'b1;
            S_PUT:   cmd.put = 1'b1;
            S_DONE:  cmd.done = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
        begin
            unique case (state_reg)
                S_IDLE:  if (start) state_reg <= S_DEC;
                S_DEC:
                begin
                    if (stat.is_clear || stat.key_zero ||
                        (!stat.is_insert && !stat.is_lookup))
                        state_reg <= S_DONE;
                    else
                        state_reg <= S_SRCH;
                end
                S_SRCH:  if (stat.srch_done) state_reg <= S_RDPOS;
                         else state_reg <= S_SWAIT;
                S_SWAIT: state_reg <= S_SRCH;
                S_RDPOS: state_reg <= S_CHK;
                S_CHK:
                begin
                    if (stat.found || stat.is_lookup || stat.full)
                        state_reg <= S_DONE;
                    else
                        state_reg <= S_SHRD;
                end
                S_SHRD:  if (stat.shift_done) state_reg <= S_PUT;
                         else state_reg <= S_SHWR;
                S_SHWR:  state_reg <= S_SHRD;
                S_PUT:   state_reg <= S_DONE;
                S_DONE:  state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

### hw/rtl/suks_dp.sv
// suks_dp: key store memory, search bounds, shift pointer and result registers
// depends on suks_pkg
module suks_dp
#(
    parameter int CAPACITY = suks_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = suks_pkg::KEY_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  suks_pkg::suks_cmd_t                 cmd,
    output suks_pkg::suks_stat_t                stat,
    input  logic [suks_pkg::OP_W-1:0]           op,
    input  logic [suks_pkg::VALUE_W-1:0]        key,
    input  logic [suks_pkg::MASK_W-1:0]         net_mask,
    output logic                                done,
    output logic [suks_pkg::VALUE_W-1:0]        value,
    output logic [suks_pkg::STATUS_W-1:0]       status,
    output logic [suks_pkg::COUNT_W-1:0]        count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = KEY_BITS;
    localparam int VW = suks_pkg::VALUE_W;

    logic [KW-1:0] mem [CAPACITY];
    logic [KW-1:0] rd_reg;

    logic [suks_pkg::OP_W-1:0]     op_reg;
    logic [KW-1:0]                 key_reg;
    logic [CW-1:0]                 cnt_reg;
    logic [CW-1:0]                 lo_reg, hi_reg, mid_reg, ptr_reg;
    logic                          pend_reg;
    logic                          found_reg;
    logic                          put_seen_reg;
    logic [suks_pkg::STATUS_W-1:0] st_reg;
    logic                          done_reg;
    logic [VW-1:0]                 val_reg;

    logic [KW-1:0] kin;
    logic [KW-1:0] mkey;
    logic [CW-1:0] mid;
    logic          rd_en;
    logic [CW-1:0] rd_addr;

    // key taken modulo 2^KEY_BITS
    always_comb
    begin
        kin = '0;
        for (int i = 0; i < KW && i < VW; i++)
            kin[i] = key[i];
    end

    // prefix mask, applied at capture for inserts
    always_comb
    begin
        mkey = kin;
        if (op == suks_pkg::OP_INSERT)
        begin
            priority if (net_mask == suks_pkg::PFX_24)
                mkey = kin & KW'(32'hFF_FFFF);
            else if (net_mask == suks_pkg::PFX_16)
                mkey = kin & KW'(32'hFFFF);
            else if (net_mask == suks_pkg::PFX_8)
                mkey = kin & KW'(32'hFF);
        end
    end

    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);

    always_comb
    begin
        rd_en = 1'b0;
        rd_addr = '0;
        if (cmd.srch_step)
        begin
            rd_en = 1'b1;
            rd_addr = mid;
        end
        else if (cmd.rd_pos)
        begin
            rd_en = 1'b1;
            rd_addr = lo_reg;
        end
        else if (cmd.shift_rd)
        begin
            rd_en = 1'b1;
            rd_addr = ptr_reg - CW'(1);
        end
    end

    // key store
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_reg <= mem[rd_addr[AW-1:0]];
        if (cmd.shift_wr)
            mem[ptr_reg[AW-1:0]] <= rd_reg;
        else if (cmd.put)
            mem[lo_reg[AW-1:0]] <= key_reg;
    end

    // item, bounds and pointers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= op;
            key_reg <= mkey;
        end
        if (cmd.srch_init)
        begin
            lo_reg   <= '0;
            hi_reg   <= cnt_reg;
            pend_reg <= 1'b0;
        end
        else if (cmd.srch_step)
        begin
            mid_reg  <= mid;
            pend_reg <= 1'b1;
        end
        else if (pend_reg)
        begin
            pend_reg <= 1'b0;
            if (rd_reg < key_reg)
                lo_reg <= mid_reg + CW'(1);
            else
                hi_reg <= mid_reg;
        end
        if (cmd.chk)
            found_reg <= (lo_reg < cnt_reg) && (rd_reg == key_reg);
        if (cmd.shift_init)
            ptr_reg <= cnt_reg;
        else if (cmd.shift_wr)
            ptr_reg <= ptr_reg - CW'(1);
    end

    // count and result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
            st_reg   <= suks_pkg::ST_MISS;
            val_reg  <= '0;
        end
        else
        begin
            done_reg <= cmd.done;
            if (cmd.clr)
                cnt_reg <= '0;
            else if (cmd.put)
                cnt_reg <= cnt_reg + CW'(1);
            if (cmd.done)
            begin
                val_reg <= '0;
                st_reg  <= suks_pkg::ST_MISS;
                if (op_reg == suks_pkg::OP_CLEAR)
                    st_reg <= suks_pkg::ST_CLEARED;
                else if (op_reg == suks_pkg::OP_INSERT)
                begin
                    priority if (key_reg == '0)
                        st_reg <= suks_pkg::ST_ZERO;
                    else if (found_reg)
                        st_reg <= suks_pkg::ST_DUPLICATE;
                    else if (!put_seen_reg)
                        st_reg <= suks_pkg::ST_FULL;
                    else
                    begin
                        st_reg  <= suks_pkg::ST_INSERTED;
                        val_reg <= VW'(key_reg);
                    end
                end
                else if (op_reg == suks_pkg::OP_LOOKUP && key_reg != '0 && found_reg)
                begin
                    st_reg  <= suks_pkg::ST_HIT;
                    val_reg <= VW'(key_reg);
                end
            end
        end
    end

    // marks that the current insert was placed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            put_seen_reg <= 1'b0;
        else if (cmd.load)
            put_seen_reg <= 1'b0;
        else if (cmd.put)
            put_seen_reg <= 1'b1;
    end

    assign stat.is_insert  = (op_reg == suks_pkg::OP_INSERT);
    assign stat.is_lookup  = (op_reg == suks_pkg::OP_LOOKUP);
    assign stat.is_clear   = (op_reg == suks_pkg::OP_CLEAR);
    assign stat.key_zero   = (key_reg == '0);
    assign stat.srch_done  = !pend_reg && (lo_reg >= hi_reg);
    assign stat.found      = (lo_reg < cnt_reg) && (rd_reg == key_reg);
    assign stat.full       = (cnt_reg >= CW'(CAPACITY));
    assign stat.shift_done = (ptr_reg == lo_reg);

    assign done   = done_reg;
    assign value  = val_reg;
    assign status = st_reg;
    assign count  = suks_pkg::COUNT_W'(cnt_reg);

endmodule

### hw/rtl/sorted_unique_key_set.sv
// sorted_unique_key_set: top level of the sorted unique key set
// depends on suks_pkg, suks_ctrl, suks_dp
//
// channel   ports                      transfer
// command   start, op, key, net_mask   start high while busy low
// result    done, value, status, count done high, one cycle
//
// steps: clear, zero key and unused op go from decode straight to done;
// a lookup or a rejected insert runs s = ceil(log2(count+1)) binary search
// steps, each a read and a compare; an accepted insert then moves every entry
// at and above the insert position up one slot and writes the key (single port key store)
// reset clears the count and result registers, not the store; entries at or past the count never match
// the receiver cannot stall, so results leave on the done strobe
module sorted_unique_key_set
#(
    parameter int CAPACITY = suks_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = suks_pkg::KEY_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [suks_pkg::OP_W-1:0]     op,
    input  logic [suks_pkg::VALUE_W-1:0]  key,
    input  logic [suks_pkg::MASK_W-1:0]   net_mask,
    output logic                          done,
    output logic [suks_pkg::VALUE_W-1:0]  value,
    output logic [suks_pkg::STATUS_W-1:0] status,
    output logic [suks_pkg::COUNT_W-1:0]  count
);

    suks_pkg::suks_cmd_t  cmd;
    suks_pkg::suks_stat_t stat;

    // sequencer
    suks_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    // store, search and result path
    suks_dp
    #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    )
    u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .op       (op),
        .key      (key),
        .net_mask (net_mask),
        .done     (done),
        .value    (value),
        .status   (status),
        .count    (count)
    );

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking testbench for the sorted unique key set
// depends on suks_pkg and sorted_unique_key_set; runs directed, fill and random tests
module tb_top;

    // one result as seen on the result ports
    typedef struct packed {
        logic [suks_pkg::VALUE_W-1:0]  value;
        logic [suks_pkg::STATUS_W-1:0] status;
        logic [suks_pkg::COUNT_W-1:0]  count;
    } answer_t;

    localparam int SET_CAP     = suks_pkg::CAPACITY_DEF;
    localparam int CYCLE_LIMIT = 20000000;
    localparam int DRAIN_WAIT  = 2 * SET_CAP + 64;

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic [suks_pkg::OP_W-1:0]     op;
    logic [suks_pkg::VALUE_W-1:0]  key;
    logic [suks_pkg::MASK_W-1:0]   net_mask;
    logic                          done;
    logic [suks_pkg::VALUE_W-1:0]  value;
    logic [suks_pkg::STATUS_W-1:0] status;
    logic [suks_pkg::COUNT_W-1:0]  count;

    // shadow copy of the set, kept ascending
    logic [suks_pkg::VALUE_W-1:0] shadow_keys[$];
    // answers predicted but not yet seen on the result ports
    answer_t                      pending_answers[$];

    int idle_pct;
    int errors;
    int items_sent;
    int answers_seen;
    int hits_seen;
    int fulls_seen;
    int cycle_cnt;

    sorted_unique_key_set dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .op       (op),
        .key      (key),
        .net_mask (net_mask),
        .done     (done),
        .value    (value),
        .status   (status),
        .count    (count)
    );

    // 10 ns clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // runaway guard
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("%0t timeout after %0d cycles", $time, cycle_cnt);
            $display("Regression FAIL");
            $finish;
        end
    end

    // predict the answer to one command and update the shadow set
    function automatic answer_t predict_answer(logic [suks_pkg::OP_W-1:0] cmd,
                                               logic [suks_pkg::VALUE_W-1:0] k,
                                               logic [suks_pkg::MASK_W-1:0] pfx);
        answer_t                      a;
        logic [suks_pkg::VALUE_W-1:0] m;
        int                           pos;
        a.value  = '0;
        a.status = suks_pkg::ST_MISS;
        m = k;
        if (cmd == suks_pkg::OP_INSERT)
        begin
            // prefix mask keeps only the low bytes
            if (pfx == suks_pkg::PFX_24)
                m = k & 32'h00FF_FFFF;
            else if (pfx == suks_pkg::PFX_16)
                m = k & 32'h0000_FFFF;
            else if (pfx == suks_pkg::PFX_8)
                m = k & 32'h0000_00FF;
            if (m == '0)
                a.status = suks_pkg::ST_ZERO;
            else
            begin
                pos = 0;
                while (pos < shadow_keys.size() && shadow_keys[pos] < m)
                    pos++;
                if (pos < shadow_keys.size() && shadow_keys[pos] == m)
                    a.status = suks_pkg::ST_DUPLICATE;
                else if (shadow_keys.size() >= SET_CAP)
                    a.status = suks_pkg::ST_FULL;
                else
                begin
                    shadow_keys.insert(pos, m);
                    a.value  = m;
                    a.status = suks_pkg::ST_INSERTED;
                end
            end
        end
        else if (cmd == suks_pkg::OP_LOOKUP)
        begin
            if (k != '0)
                foreach (shadow_keys[i])
                    if (shadow_keys[i] == k)
                    begin
                        a.value  = k;
                        a.status = suks_pkg::ST_HIT;
                    end
        end
        else if (cmd == suks_pkg::OP_CLEAR)
        begin
            shadow_keys.delete();
            a.status = suks_pkg::ST_CLEARED;
        end
        // unused op code leaves the set alone and answers a miss
        a.count = suks_pkg::COUNT_W'(shadow_keys.size());
        return a;
    endfunction

    // drive one command at the falling edge and hold it until the transfer
    task automatic send_cmd(logic [suks_pkg::OP_W-1:0] cmd, logic [suks_pkg::VALUE_W-1:0] k,
                            logic [suks_pkg::MASK_W-1:0] pfx);
        int gap;
        @(negedge clk);
        // sender idles before some commands
        if ($urandom_range(99) < idle_pct)
        begin
            start = 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(negedge clk);
        end
        start    = 1'b1;
        op       = cmd;
        key      = k;
        net_mask = pfx;
        // transfer happens on the rising edge where busy is low
        do
            @(posedge clk);
        while (busy);
        pending_answers.push_back(predict_answer(cmd, k, pfx));
        items_sent++;
    endtask

    // drop start once the last command has been taken
    task automatic stop_sending();
        @(negedge clk);
        start = 1'b0;
    endtask

    // result checker: every done strobe is matched against the oldest prediction
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && done)
        begin
            answers_seen++;
            if (pending_answers.size() == 0)
            begin
                $display("%0t unexpected result value=%h status=%0d count=%0d",
                         $time, value, status, count);
                errors++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (status == suks_pkg::ST_HIT)
                    hits_seen++;
                if (status == suks_pkg::ST_FULL)
                    fulls_seen++;
                if (value !== want.value)
                begin
                    $display("%0t value mismatch: expected %h actual %h",
                             $time, want.value, value);
                    errors++;
                end
                if (status !== want.status)
                begin
                    $display("%0t status mismatch: expected %0d actual %0d",
                             $time, want.status, status);
                    errors++;
                end
                if (count !== want.count)
                begin
                    $display("%0t count mismatch: expected %0d actual %0d",
                             $time, want.count, count);
                    errors++;
                end
            end
        end
    end

    // corner cases: masks, zero keys, duplicates, lookups, unused op, clear
    task automatic test_directed();
        send_cmd(suks_pkg::OP_LOOKUP, 32'h1234_5678, 6'd0);          // lookup in empty set
        send_cmd(suks_pkg::OP_INSERT, 32'h0000_0000, 6'd0);          // zero key
        send_cmd(suks_pkg::OP_INSERT, 32'hFFFF_FF00, suks_pkg::PFX_8); // masked down to zero
        send_cmd(suks_pkg::OP_INSERT, 32'hABCD_EF12, suks_pkg::PFX_8);
        send_cmd(suks_pkg::OP_INSERT, 32'hABCD_EF12, suks_pkg::PFX_16);
        send_cmd(suks_pkg::OP_INSERT, 32'hABCD_EF12, suks_pkg::PFX_24);
        send_cmd(suks_pkg::OP_INSERT, 32'hABCD_EF12, 6'd32);
        send_cmd(suks_pkg::OP_INSERT, 32'hFFFF_FFFF, 6'd63);         // top key, odd mask
        send_cmd(suks_pkg::OP_INSERT, 32'h0000_0001, 6'd0);          // lowest key
        send_cmd(suks_pkg::OP_INSERT, 32'h77AB_CDEF, suks_pkg::PFX_16); // new key after mask
        send_cmd(suks_pkg::OP_INSERT, 32'hFFFF_FFFF, 6'd0);          // duplicate
        send_cmd(suks_pkg::OP_LOOKUP, 32'h00CD_EF12, 6'd0);          // hit
        send_cmd(suks_pkg::OP_LOOKUP, 32'hFFFF_FFFF, suks_pkg::PFX_8); // hit, mask ignored
        send_cmd(suks_pkg::OP_LOOKUP, 32'h00CD_EF13, 6'd0);          // miss
        send_cmd(suks_pkg::OP_LOOKUP, 32'h0000_0000, 6'd0);          // lookup of zero
        send_cmd(2'd3, 32'h0000_0001, 6'd0);                         // unused op code
        send_cmd(suks_pkg::OP_CLEAR, 32'hFFFF_FFFF, 6'd63);
        send_cmd(suks_pkg::OP_LOOKUP, 32'h0000_0001, 6'd0);          // gone after clear
        send_cmd(suks_pkg::OP_INSERT, 32'h8000_0000, 6'd1);
    endtask

    // fill to capacity with a worst-case front insert, then probe the full set
    task automatic test_fill_full();
        send_cmd(suks_pkg::OP_CLEAR, '0, '0);
        for (int i = 1; i < SET_CAP; i++)
            send_cmd(suks_pkg::OP_INSERT, 32'h1000 + i * 32'h10, 6'd0);
        send_cmd(suks_pkg::OP_INSERT, 32'h1000, 6'd0);        // lands at the front, moves all
        send_cmd(suks_pkg::OP_INSERT, 32'h0000_0005, 6'd0);   // full
        send_cmd(suks_pkg::OP_INSERT, 32'hFFFF_FFFF, 6'd0);   // full
        send_cmd(suks_pkg::OP_INSERT, 32'h1010, 6'd0);        // duplicate while full
        send_cmd(suks_pkg::OP_INSERT, 32'h0, 6'd0);           // zero while full
        send_cmd(suks_pkg::OP_LOOKUP, 32'h1000 + (SET_CAP - 1) * 32'h10, 6'd0);
        send_cmd(suks_pkg::OP_LOOKUP, 32'h1008, 6'd0);
        send_cmd(suks_pkg::OP_CLEAR, '0, '0);
    endtask

    // random mix; keys drawn from narrow pools so duplicates and hits are common
    task automatic test_random(int n_items);
        logic [suks_pkg::OP_W-1:0]    cmd;
        logic [suks_pkg::VALUE_W-1:0] k;
        logic [suks_pkg::MASK_W-1:0]  pfx;
        int                           pick;
        for (int i = 0; i < n_items; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 50)
                cmd = suks_pkg::OP_INSERT;
            else if (pick < 94)
                cmd = suks_pkg::OP_LOOKUP;
            else if (pick < 97)
                cmd = suks_pkg::OP_CLEAR;
            else
                cmd = 2'd3;
            case ($urandom_range(3))
                0:       k = $urandom();
                1:       k = $urandom_range(0, 63);
                2:       k = {2'($urandom_range(0, 3)), 22'd0, 8'($urandom_range(0, 15))};
                default: k = (shadow_keys.size() > 0) ?
                             shadow_keys[$urandom_range(0, shadow_keys.size() - 1)] :
                             $urandom();
            endcase
            case ($urandom_range(5))
                0:       pfx = suks_pkg::PFX_8;
                1:       pfx = suks_pkg::PFX_16;
                2:       pfx = suks_pkg::PFX_24;
                3:       pfx = 6'd32;
                default: pfx = suks_pkg::MASK_W'($urandom_range(0, 63));
            endcase
            send_cmd(cmd, k, pfx);
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        op         = suks_pkg::OP_LOOKUP;
        key        = '0;
        net_mask   = '0;
        idle_pct   = 0;
        errors     = 0;
        items_sent = 0;
        answers_seen = 0;
        hits_seen  = 0;
        fulls_seen = 0;
        cycle_cnt  = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        idle_pct = 54;
        test_fill_full();
        // random phases: steady stream, sparse sender, light idling
        idle_pct = 0;
        test_random(320);
        idle_pct = 54;
        test_random(320);
        idle_pct = 17;
        test_random(320);
        stop_sending();

        // wait for the last results, then a quiet stretch for stray strobes
        while (pending_answers.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("covered %0d commands, %0d results checked, %0d hits, %0d full rejects",
                 items_sent, answers_seen, hits_seen, fulls_seen);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

### files.f
hw/rtl/suks_pkg.sv
hw/rtl/suks_ctrl.sv
hw/rtl/suks_dp.sv
hw/rtl/sorted_unique_key_set.sv
bench/tb_top.sv
